FILE: hdl/srsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window block.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int SEQ_W      = 4;
  localparam int SEQ_COUNT  = 1 << SEQ_W;
  localparam int WIN_W      = 4;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);
  // selective-repeat limit: half the sequence space
  localparam logic [WIN_W-1:0] WIN_LIMIT = WIN_W'(SEQ_COUNT / 2);

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [1:0] {
    MODE_NEW     = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SEND   = 2'd1,
    ACT_RESEND = 2'd2,
    ACT_FULL   = 2'd3
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;  // capture input word
    logic exec;   // evaluate event
    logic walk;   // move base past one acked slot
    logic load;   // load output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_more;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/srsw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer: accept one word, evaluate it, walk the base, hand off the result.
// ----------------------------------------------------------------------------
module srsw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srsw_pkg::dp_stat_t  stat,
  output srsw_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = ST_WALK;
      ST_WALK: if (!stat.walk_more) state_next = ST_FIN;
      ST_FIN:  if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

  assign cmd.latch = in_valid && in_ready;
  assign cmd.exec  = (state == ST_EXEC);
  assign cmd.walk  = (state == ST_WALK) && stat.walk_more;
  assign cmd.load  = (state == ST_FIN) && stat.out_free;

endmodule

FILE: hdl/srsw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_dp
// Window state (base, next, ack marks), event evaluation, output register.
// ----------------------------------------------------------------------------
module srsw_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [srsw_pkg::WIN_W-1:0]   cfg_data,
  input  logic [1:0]                   mode,
  input  srsw_pkg::seq_t               seq,
  input  logic                         checksum_ok,
  input  srsw_pkg::ctrl_cmd_t          cmd,
  output srsw_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   action,
  output srsw_pkg::seq_t               out_seq,
  output logic                         start_timer,
  output logic                         stop_timer,
  output srsw_pkg::seq_t               window_base,
  output srsw_pkg::seq_t               next_to_send,
  output logic                         all_acked
);

  logic [srsw_pkg::WIN_W-1:0]     window_size;
  logic [srsw_pkg::WIN_W-1:0]     win_eff;
  srsw_pkg::seq_t                 base_seq;
  srsw_pkg::seq_t                 next_seq;
  logic [srsw_pkg::SEQ_COUNT-1:0] acked_marks;

  srsw_pkg::mode_t   mode_q;
  srsw_pkg::seq_t    seq_q;
  logic              csum_q;

  srsw_pkg::action_t res_action;
  srsw_pkg::seq_t    res_seq;
  logic              res_start;
  logic              res_stop;

  srsw_pkg::seq_t    dist_out;
  srsw_pkg::seq_t    dist_seq;
  logic              outstanding;

  // modulo arithmetic falls out of the 4-bit wrap
  assign dist_out    = next_seq - base_seq;
  assign dist_seq    = seq_q - base_seq;
  assign outstanding = dist_seq < dist_out;

  always_comb begin
    priority if (window_size == '0)
      win_eff = srsw_pkg::WIN_W'(1);
    else if (window_size > srsw_pkg::WIN_LIMIT)
      win_eff = srsw_pkg::WIN_LIMIT;
    else
      win_eff = window_size;
  end

  assign stat.walk_more = (base_seq != next_seq) && acked_marks[base_seq];
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= srsw_pkg::WIN_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= srsw_pkg::mode_t'(mode);
      seq_q  <= seq;
      csum_q <= checksum_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq    <= '0;
      next_seq    <= '0;
      acked_marks <= '0;
    end else if (cmd.exec) begin
      unique case (mode_q)
        srsw_pkg::MODE_NEW: begin
          if (dist_out < win_eff) next_seq <= next_seq + 1'b1;
        end
        srsw_pkg::MODE_ACK: begin
          if (csum_q && outstanding) begin
            if (seq_q == base_seq) begin
              acked_marks[seq_q] <= 1'b0;
              base_seq           <= seq_q + 1'b1;
            end else begin
              acked_marks[seq_q] <= 1'b1;
            end
          end
        end
        srsw_pkg::MODE_TIMEOUT,
        srsw_pkg::MODE_NOP: ;
        default: ;
      endcase
    end else if (cmd.walk) begin
      acked_marks[base_seq] <= 1'b0;
      base_seq              <= base_seq + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_action <= srsw_pkg::ACT_NONE;
      res_seq    <= '0;
      res_start  <= 1'b0;
      res_stop   <= 1'b0;
      unique case (mode_q)
        srsw_pkg::MODE_NEW: begin
          if (dist_out < win_eff) begin
            res_action <= srsw_pkg::ACT_SEND;
            res_seq    <= next_seq;
            res_start  <= 1'b1;
          end else begin
            res_action <= srsw_pkg::ACT_FULL;
          end
        end
        srsw_pkg::MODE_ACK: begin
          if (csum_q && outstanding) begin
            res_seq  <= seq_q;
            res_stop <= 1'b1;
          end
        end
        srsw_pkg::MODE_TIMEOUT: begin
          if (outstanding) begin
            res_action <= srsw_pkg::ACT_RESEND;
            res_seq    <= seq_q;
            res_start  <= 1'b1;
          end
        end
        srsw_pkg::MODE_NOP: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action       <= res_action;
      out_seq      <= res_seq;
      start_timer  <= res_start;
      stop_timer   <= res_stop;
      window_base  <= base_seq;
      next_to_send <= next_seq;
      all_acked    <= (base_seq == next_seq);
    end
  end

endmodule

FILE: hdl/selective_repeat_sender_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_top
// Sender window control for selective-repeat ARQ: send, ack, timeout events.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | mode, seq, checksum_ok
//  output   | out_valid / out_ready| action, out_seq, start/stop_timer,
//           |                      | window_base, next_to_send, all_acked
//  config   | cfg_we               | cfg_data (window_size)
//
//  Each word is latched and evaluated, then the base walks one slot per cycle
//  past already-acked slots (at most 7), then the result is loaded.
//  One word is in flight at a time; in_ready is low until its result is
//  loaded into the output register. A stalled output holds the block in
//  its final state. Synchronous reset: window 4, base = next = 0, no marks.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [srsw_pkg::WIN_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic [srsw_pkg::SEQ_W-1:0] seq,
  input  logic                       checksum_ok,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 action,
  output logic [srsw_pkg::SEQ_W-1:0] out_seq,
  output logic                       start_timer,
  output logic                       stop_timer,
  output logic [srsw_pkg::SEQ_W-1:0] window_base,
  output logic [srsw_pkg::SEQ_W-1:0] next_to_send,
  output logic                       all_acked
);

  srsw_pkg::ctrl_cmd_t cmd;
  srsw_pkg::dp_stat_t  stat;

  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srsw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .seq          (seq),
    .checksum_ok  (checksum_ok),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .out_seq      (out_seq),
    .start_timer  (start_timer),
    .stop_timer   (stop_timer),
    .window_base  (window_base),
    .next_to_send (next_to_send),
    .all_acked    (all_acked)
  );

endmodule

FILE: hdl/srsw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks of the sender window block, bound to the top level.
// ----------------------------------------------------------------------------
module srsw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 action,
  input logic [srsw_pkg::SEQ_W-1:0] out_seq,
  input logic                       start_timer,
  input logic                       stop_timer,
  input logic [srsw_pkg::SEQ_W-1:0] window_base,
  input logic [srsw_pkg::SEQ_W-1:0] next_to_send
);

  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in flight");

  // a send or resend always restarts a timer and never stops one
  a_send_timer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (action == srsw_pkg::ACT_SEND || action == srsw_pkg::ACT_RESEND))
      |-> (start_timer && !stop_timer))
    else $error("send without timer start");

  // a refused packet touches no timer and names no sequence number
  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == srsw_pkg::ACT_FULL)
      |-> (!start_timer && !stop_timer && out_seq == '0))
    else $error("refused packet with timer activity");

  // a new send is the last assigned number, one behind next_to_send
  a_send_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == srsw_pkg::ACT_SEND)
      |-> (srsw_pkg::seq_t'(out_seq + 1'b1) == next_to_send && window_base != next_to_send))
    else $error("send number does not match next_to_send");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(action) && $stable(out_seq)
      && $stable(window_base)))
    else $error("stalled result changed");

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .action       (action),
  .out_seq      (out_seq),
  .start_timer  (start_timer),
  .stop_timer   (stop_timer),
  .window_base  (window_base),
  .next_to_send (next_to_send)
);

FILE: tb/sv/tb_selective_repeat_sender_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window_top
// Self-checking bench for the selective-repeat sender window block: directed
// send/ack/timeout cases, then random link traffic under several window
// settings, with random idle on both channels and a scoreboard of predicted
// result words.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window_top;
  import srsw_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [WIN_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       mode = MODE_NOP;
  seq_t             seq = '0;
  logic             checksum_ok = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       action;
  seq_t             out_seq;
  logic             start_timer;
  logic             stop_timer;
  seq_t             window_base;
  seq_t             next_to_send;
  logic             all_acked;

  typedef struct {
    action_t act;
    seq_t    oseq;
    logic    start;
    logic    stop;
    seq_t    base;
    seq_t    nxt;
    logic    idle;
  } sender_word_t;

  // predicted sender state
  logic [WIN_W-1:0] window_cfg = WIN_RESET;
  seq_t             sent_base = '0;
  seq_t             sent_next = '0;
  logic             acked_slot [SEQ_COUNT];

  sender_word_t expected_words [$];
  int           mismatches = 0;
  bit           no_idle = 1'b0;

  selective_repeat_sender_window_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .seq          (seq),
    .checksum_ok  (checksum_ok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .out_seq      (out_seq),
    .start_timer  (start_timer),
    .stop_timer   (stop_timer),
    .window_base  (window_base),
    .next_to_send (next_to_send),
    .all_acked    (all_acked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // Next window state and result word for one event.
  function automatic sender_word_t sender_step(mode_t m, seq_t s, logic ok);
    sender_word_t     w;
    logic [WIN_W-1:0] win;
    seq_t             span;
    int               guard;
    w.act   = ACT_NONE;
    w.oseq  = '0;
    w.start = 1'b0;
    w.stop  = 1'b0;
    win = window_cfg;
    if (win == '0) win = WIN_W'(1);
    if (win > WIN_LIMIT) win = WIN_LIMIT;
    span = sent_next - sent_base;
    case (m)
      MODE_NEW: begin
        if (span < win) begin
          w.act     = ACT_SEND;
          w.oseq    = sent_next;
          w.start   = 1'b1;
          sent_next = sent_next + 1'b1;
        end else begin
          w.act = ACT_FULL;
        end
      end
      MODE_ACK: begin
        if (ok && seq_t'(s - sent_base) < span) begin
          w.stop = 1'b1;
          w.oseq = s;
          if (s == sent_base) begin
            acked_slot[s] = 1'b0;
            sent_base = s + 1'b1;
            guard = 0;
            // base walks past slots that were acked out of order
            while (sent_base != sent_next && acked_slot[sent_base] && guard < SEQ_COUNT) begin
              acked_slot[sent_base] = 1'b0;
              sent_base = sent_base + 1'b1;
              guard++;
            end
          end else begin
            acked_slot[s] = 1'b1;
          end
        end
      end
      MODE_TIMEOUT: begin
        if (seq_t'(s - sent_base) < span) begin
          w.act   = ACT_RESEND;
          w.oseq  = s;
          w.start = 1'b1;
        end
      end
      default: ;
    endcase
    w.base = sent_base;
    w.nxt  = sent_next;
    w.idle = (sent_base == sent_next);
    return w;
  endfunction

  task automatic send_word(mode_t m, seq_t s, logic ok);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    mode        = m;
    seq         = s;
    checksum_ok = ok;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(sender_step(m, s, ok));
  endtask

  // Drain all outstanding words; leaves the block idle.
  task automatic wait_idle;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_window(logic [WIN_W-1:0] w);
    wait_idle();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = w;
    @(negedge clk);
    cfg_we     = 1'b0;
    window_cfg = w;
  endtask

  // output side: random stall before each word
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (rst || !out_valid);
    end
  end

  always @(posedge clk) begin
    sender_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: action=%0d seq=%0d", action, out_seq);
      end else begin
        e = expected_words.pop_front();
        if (action !== e.act || out_seq !== e.oseq || start_timer !== e.start ||
            stop_timer !== e.stop || window_base !== e.base ||
            next_to_send !== e.nxt || all_acked !== e.idle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp act=%0d seq=%0d start=%0b stop=%0b base=%0d next=%0d all=%0b",
                     e.act, e.oseq, e.start, e.stop, e.base, e.nxt, e.idle,
                     " | got act=%0d seq=%0d start=%0b stop=%0b base=%0d next=%0d all=%0b",
                     action, out_seq, start_timer, stop_timer, window_base,
                     next_to_send, all_acked);
        end
      end
    end
  end

  // events with an empty window: all ignored
  task automatic test_idle_events;
    send_word(MODE_NOP, 4'd15, 1'b1);
    send_word(MODE_TIMEOUT, 4'd0, 1'b1);
    send_word(MODE_ACK, 4'd0, 1'b1);
  endtask

  // reset window of 4: four sends, then refused
  task automatic test_window_fill;
    repeat (5) send_word(MODE_NEW, 4'd0, 1'b0);
  endtask

  task automatic test_ack_handling;
    send_word(MODE_ACK, 4'd2, 1'b1);      // out of order, marked
    send_word(MODE_ACK, 4'd2, 1'b1);      // repeated
    send_word(MODE_ACK, 4'd0, 1'b0);      // bad checksum
    send_word(MODE_TIMEOUT, 4'd3, 1'b0);  // resend
    send_word(MODE_TIMEOUT, 4'd9, 1'b1);  // stray timeout
    send_word(MODE_ACK, 4'd0, 1'b1);      // base moves to 1
    send_word(MODE_ACK, 4'd1, 1'b1);      // walks past marked 2
    send_word(MODE_ACK, 4'd3, 1'b1);      // window empty again
    send_word(MODE_ACK, 4'd3, 1'b1);      // no longer outstanding
  endtask

  // window 0 acts as 1
  task automatic test_window_zero;
    set_window('0);
    send_word(MODE_NEW, 4'd7, 1'b1);
    send_word(MODE_NEW, 4'd8, 1'b0);
    send_word(MODE_ACK, 4'd4, 1'b1);
  endtask

  // Mostly well-formed traffic against the live window, some noise.
  task automatic test_random_traffic(int n, logic [WIN_W-1:0] w, bit burst);
    int   r;
    seq_t span;
    seq_t s;
    set_window(w);
    no_idle = burst;
    for (int i = 0; i < n; i++) begin
      r    = $urandom_range(0, 99);
      span = sent_next - sent_base;
      s    = seq_t'($urandom_range(0, SEQ_COUNT - 1));
      if (span != 0 && r >= 35 && r < 80)
        s = sent_base + seq_t'($urandom_range(0, span - 1));
      if (r < 35)
        send_word(MODE_NEW, s, 1'($urandom_range(0, 1)));
      else if (r < 70)
        send_word(MODE_ACK, s, 1'b1);
      else if (r < 80)
        send_word(MODE_TIMEOUT, s, 1'($urandom_range(0, 1)));
      else if (r < 85)
        send_word(MODE_ACK, s, 1'b1);
      else if (r < 90)
        send_word(MODE_ACK, s, 1'b0);
      else if (r < 95)
        send_word(MODE_TIMEOUT, s, 1'($urandom_range(0, 1)));
      else
        send_word(MODE_NOP, s, 1'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SEQ_COUNT; i++) acked_slot[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_events();
    test_window_fill();
    test_ack_handling();
    test_window_zero();

    test_random_traffic(96, 4'd15, 1'b0);
    test_random_traffic(96, WIN_LIMIT, 1'b0);
    test_random_traffic(96, 4'd1, 1'b1);
    test_random_traffic(96, 4'($urandom_range(2, 7)), 1'b0);
    test_random_traffic(96, 4'd0, 1'b0);

    wait_idle();
    if (mismatches == 0 && expected_words.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/srsw_pkg.sv
hdl/srsw_ctrl.sv
hdl/srsw_dp.sv
hdl/selective_repeat_sender_window_top.sv
hdl/srsw_checker.sv
tb/sv/tb_selective_repeat_sender_window_top.sv
